// ===== sv/spmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmc_pkg: shared types and constants for the supercap power-mode controller
// Field widths, mode and sequencer codes, register indexes and the
// reciprocal constants used for the constant divisions.
// ----------------------------------------------------------------------------
package spmc_pkg;

   // Payload and register widths.
   localparam int VOLT_W      = 16;
   localparam int ERR_W       = 8;
   localparam int PIN_W       = 9;
   localparam int POUT_W      = 10;
   localparam int MODE_W      = 3;
   localparam int THR_W       = 15;
   localparam int BONUS_W     = 8;
   localparam int BOOST_W     = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 15;

   // Shared multiplier geometry.
   localparam int MUL_A_W     = 18;
   localparam int MUL_B_W     = 25;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int RECIP_SHIFT = 27;
   localparam int QUOT_W      = 10;

   // ceil(2^27 / 5) and ceil(2^27 / 400): exact floor division over the
   // operand ranges that reach the multiplier.
   localparam logic [MUL_B_W-1:0] RECIP_DIV5   = 25'd26843546;
   localparam logic [MUL_B_W-1:0] RECIP_DIV400 = 25'd335545;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_THR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEAK_THR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_THR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BONUS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST     = 3'd5;

   // Register reset values.
   localparam logic [THR_W-1:0]   FULL_THR_RST  = 15'd18000;
   localparam logic [THR_W-1:0]   WEAK_THR_RST  = 15'd12000;
   localparam logic [THR_W-1:0]   LOW_THR_RST   = 15'd10000;
   localparam logic [THR_W-1:0]   EMPTY_THR_RST = 15'd8000;
   localparam logic [BONUS_W-1:0] BONUS_RST     = 8'd20;
   localparam logic [BOOST_W-1:0] BOOST_RST     = 10'd200;

   // Request opcodes.
   localparam logic OP_FEEDBACK = 1'b0;
   localparam logic OP_CONTROL  = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_SAFETY  = 3'd0,
      MODE_FORCED  = 3'd1,
      MODE_CHARGE  = 3'd2,
      MODE_PASSIVE = 3'd3,
      MODE_ACTIVE  = 3'd4
   } spmc_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SQUARE,
      S_DIV5,
      S_DIV400,
      S_FINISH
   } spmc_state_type;

   typedef struct packed {
      logic [THR_W-1:0]   full_thr;
      logic [THR_W-1:0]   weak_thr;
      logic [THR_W-1:0]   low_thr;
      logic [THR_W-1:0]   empty_thr;
      logic [BONUS_W-1:0] bonus;
      logic [BOOST_W-1:0] boost;
   } spmc_cfg_type;

   typedef struct packed {
      logic signed [VOLT_W-1:0] voltage;
      logic [ERR_W-1:0]         error;
   } spmc_fb_type;

   typedef struct packed {
      logic             valid;
      logic             opcode;
      logic             boost;
      logic [PIN_W-1:0] chassis_w;
   } spmc_beat_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } spmc_mul_req_type;

endpackage

// ===== sv/spmc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmc_if: request and response channels of the power-mode controller
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface spmc_req_if;
   import spmc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic signed [VOLT_W-1:0] cap_voltage_mv;
   logic [ERR_W-1:0]         error_code;
   logic                     boost_request;
   logic [PIN_W-1:0]         power_limit_w;

   modport source (
      output valid, opcode, cap_voltage_mv, error_code, boost_request, power_limit_w,
      input  ready
   );
   modport sink (
      input  valid, opcode, cap_voltage_mv, error_code, boost_request, power_limit_w,
      output ready
   );
endinterface

interface spmc_rsp_if;
   import spmc_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [POUT_W-1:0] max_power_w;

   modport source (
      output valid, mode, max_power_w,
      input  ready
   );
   modport sink (
      input  valid, mode, max_power_w,
      output ready
   );
endinterface

// ===== sv/spmc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmc_mul: shared multiplier
// One registered 18 x 25 multiplier, used for the squaring and for the
// reciprocal multiplications that replace the constant divisions.
// ----------------------------------------------------------------------------
module spmc_mul
   import spmc_pkg::*;
(
   input  logic                 clock,
   input  spmc_mul_req_type     mul_req,
   output logic [MUL_P_W-1:0]   product
);

   logic [MUL_P_W-1:0] product_ff;
   logic [MUL_P_W-1:0] product_in;

   // Product of the operands offered this cycle.
   assign product_in = MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);

   // The product only advances when the sequencer issues an operation.
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== sv/spmc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmc_seq: mode sequencer
// Steps the five-mode machine on each control beat, drives the shared
// multiplier for the power formulas and holds the response register.
// ----------------------------------------------------------------------------
module spmc_seq
   import spmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  spmc_cfg_type         cfg,
   input  spmc_fb_type          fb,
   input  spmc_beat_type        req,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output spmc_mode_type        rsp_mode,
   output logic [POUT_W-1:0]    rsp_power,
   output spmc_mul_req_type     mul_req,
   input  logic [MUL_P_W-1:0]   mul_product
);

   spmc_state_type    state_ff, state_in;
   spmc_mode_type     mode_ff, mode_in, mode_next;
   logic [PIN_W-1:0]  p_ff, p_in;
   logic              boost_ff, boost_in;
   logic              rsp_valid_ff, rsp_valid_in;
   spmc_mode_type     rsp_mode_ff, rsp_mode_in;
   logic [POUT_W-1:0] rsp_power_ff, rsp_power_in;

   logic              accept;
   logic              load;
   logic              v_below_weak, v_below_low, v_below_empty, v_above_full;
   logic [QUOT_W-1:0] quotient;
   logic [POUT_W-1:0] p_ext;
   logic [POUT_W-1:0] power;

   assign accept = req.valid && req_ready;
   assign load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Threshold compares against the stored voltage; a negative voltage is
   // below every threshold.
   assign v_below_weak  = fb.voltage < $signed({1'b0, cfg.weak_thr});
   assign v_below_low   = fb.voltage < $signed({1'b0, cfg.low_thr});
   assign v_below_empty = fb.voltage < $signed({1'b0, cfg.empty_thr});
   assign v_above_full  = fb.voltage > $signed({1'b0, cfg.full_thr});

   // Mode transition; a stored fault forces safety.
   always_comb begin
      mode_next = MODE_SAFETY;
      if (fb.error == '0) begin
         case (mode_ff)
            MODE_FORCED: begin
               if (v_below_empty)     mode_next = MODE_SAFETY;
               else if (v_above_full) mode_next = MODE_PASSIVE;
               else                   mode_next = MODE_FORCED;
            end
            MODE_CHARGE: begin
               if (v_below_low)       mode_next = MODE_FORCED;
               else if (v_above_full) mode_next = MODE_PASSIVE;
               else                   mode_next = MODE_CHARGE;
            end
            MODE_PASSIVE: begin
               if (boost_ff)          mode_next = MODE_ACTIVE;
               else if (v_below_weak) mode_next = MODE_CHARGE;
               else if (!v_above_full) mode_next = MODE_SAFETY;
               else                   mode_next = MODE_PASSIVE;
            end
            MODE_ACTIVE: begin
               if (v_below_weak)      mode_next = MODE_CHARGE;
               else if (!boost_ff)    mode_next = MODE_PASSIVE;
               else                   mode_next = MODE_ACTIVE;
            end
            default: begin
               if (boost_ff)          mode_next = MODE_ACTIVE;
               else if (v_above_full) mode_next = MODE_PASSIVE;
               else                   mode_next = MODE_SAFETY;
            end
         endcase
      end
   end

   // Power allowed in the registered mode; forced and charging modes use the last multiplier result.
   assign quotient = mul_product[RECIP_SHIFT +: QUOT_W];
   assign p_ext    = POUT_W'(p_ff);

   always_comb begin
      case (mode_ff)
         MODE_FORCED:  power = quotient;
         MODE_CHARGE:  power = (quotient >= p_ext) ? '0 : p_ext - quotient;
         MODE_PASSIVE: power = v_above_full ? p_ext + POUT_W'(cfg.bonus) : p_ext;
         MODE_ACTIVE:  power = cfg.boost;
         default:      power = p_ext;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req.opcode == OP_CONTROL)) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (mode_next == MODE_FORCED)      state_in = S_DIV5;
            else if (mode_next == MODE_CHARGE) state_in = S_SQUARE;
            else                               state_in = S_FINISH;
         end
         S_SQUARE: state_in = S_DIV400;
         S_DIV5:   state_in = S_FINISH;
         S_DIV400: state_in = S_FINISH;
         S_FINISH: begin
            if (load) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // State outputs: request ready and multiplier operands.
   always_comb begin
      req_ready = 1'b0;
      mul_req   = '0;
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_SQUARE: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(p_ff);
            mul_req.b  = MUL_B_W'(p_ff);
         end
         S_DIV5: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'({p_ff, 1'b0});
            mul_req.b  = RECIP_DIV5;
         end
         S_DIV400: begin
            mul_req.en = 1'b1;
            mul_req.a  = mul_product[MUL_A_W-1:0];
            mul_req.b  = RECIP_DIV400;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      p_in         = accept ? req.chassis_w : p_ff;
      boost_in     = accept ? req.boost : boost_ff;
      mode_in      = (state_ff == S_DECIDE) ? mode_next : mode_ff;
      rsp_mode_in  = load ? mode_ff : rsp_mode_ff;
      rsp_power_in = load ? power : rsp_power_ff;
      if (load)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_SAFETY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      boost_ff     <= boost_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_power_ff <= rsp_power_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mode  = rsp_mode_ff;
   assign rsp_power = rsp_power_ff;

   // A beat is only taken while the sequencer is idle.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE))
      else $error("request beat taken outside idle");

   // A control beat always starts the mode decision.
   a_control_decides: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.opcode == OP_CONTROL)) |=> (state_ff == S_DECIDE))
      else $error("control beat did not start a decision");

   // A response is only loaded from the finish step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response loaded outside finish");

   // In forced charging, floor(2p/5) never exceeds p.
   a_forced_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && (mode_ff == MODE_FORCED)) |-> (quotient <= p_ext))
      else $error("forced-charging power above limit");

endmodule

// ===== sv/supercap_power_mode_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supercap_power_mode_controller: supercapacitor power-mode controller
// Stores capacitor feedback, steps the five-mode machine on control beats
// and returns the mode with the chassis power allowed in it.
// ----------------------------------------------------------------------------
// A feedback beat (opcode 0) stores the capacitor voltage and error byte
// and returns nothing. A control beat (opcode 1) steps the sequencer from
// idle through decide, then any multiplier steps, then finish, where the
// response register loads, and back to idle, where the next beat can be
// taken; safety, passive and active mode need no multiplier step.
// The extra steps are passes through the single shared multiplier (one for
// floor(2p/5), two for the square and floor(p*p/400)). The request side is
// ready only while the sequencer is idle; a finished response waits in its
// output register, so new beats are taken while it is pending, and a second
// control beat holds in its last step until that register is free.
// Thresholds and allowances are written through the csr port; the user
// writes them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module supercap_power_mode_controller
   import spmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   spmc_req_if.sink               req_chan,
   spmc_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   spmc_cfg_type     cfg_ff, cfg_in;
   spmc_fb_type      fb_ff, fb_in;
   spmc_beat_type    beat;
   spmc_mul_req_type mul_req;
   spmc_mode_type    rsp_mode;
   logic [MUL_P_W-1:0] mul_product;
   logic             req_ready;
   logic             accept;

   assign accept = req_chan.valid && req_ready;

   // Configuration register writes; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FULL_THR:  cfg_in.full_thr  = csr_wdata[THR_W-1:0];
            CSR_WEAK_THR:  cfg_in.weak_thr  = csr_wdata[THR_W-1:0];
            CSR_LOW_THR:   cfg_in.low_thr   = csr_wdata[THR_W-1:0];
            CSR_EMPTY_THR: cfg_in.empty_thr = csr_wdata[THR_W-1:0];
            CSR_BONUS:     cfg_in.bonus     = csr_wdata[BONUS_W-1:0];
            CSR_BOOST:     cfg_in.boost     = csr_wdata[BOOST_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Feedback beats replace the stored voltage and error.
   always_comb begin
      fb_in = fb_ff;
      if (accept && (req_chan.opcode == OP_FEEDBACK)) begin
         fb_in.voltage = req_chan.cap_voltage_mv;
         fb_in.error   = req_chan.error_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_thr  <= FULL_THR_RST;
         cfg_ff.weak_thr  <= WEAK_THR_RST;
         cfg_ff.low_thr   <= LOW_THR_RST;
         cfg_ff.empty_thr <= EMPTY_THR_RST;
         cfg_ff.bonus     <= BONUS_RST;
         cfg_ff.boost     <= BOOST_RST;
         fb_ff            <= '0;
      end else begin
         cfg_ff <= cfg_in;
         fb_ff  <= fb_in;
      end
   end

   // Request beat seen by the sequencer.
   assign beat.valid     = req_chan.valid;
   assign beat.opcode    = req_chan.opcode;
   assign beat.boost     = req_chan.boost_request;
   assign beat.chassis_w = req_chan.power_limit_w;

   assign req_chan.ready = req_ready;

   spmc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .fb          (fb_ff),
      .req         (beat),
      .req_ready   (req_ready),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_mode    (rsp_mode),
      .rsp_power   (rsp_chan.max_power_w),
      .mul_req     (mul_req),
      .mul_product (mul_product)
   );

   spmc_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (mul_product)
   );

   assign rsp_chan.mode = rsp_mode;

endmodule
